/* rtl/mcs_pkg.sv */
// Shared types, codes and reset constants for the motion command sequencer.
// Used by mcs_core and motion_command_sequencer; no dependencies.
package mcs_pkg;

  // Event kinds
  localparam logic [1:0] CMD_MOTION  = 2'd0;
  localparam logic [1:0] CMD_HEADING = 2'd1;
  localparam logic [1:0] CMD_DIST    = 2'd2;

  // Motion codes
  localparam logic [3:0] MOT_FWD          = 4'd0;
  localparam logic [3:0] MOT_BACK         = 4'd1;
  localparam logic [3:0] MOT_STRAFE_LEFT  = 4'd2;
  localparam logic [3:0] MOT_STRAFE_RIGHT = 4'd3;
  localparam logic [3:0] MOT_CW           = 4'd4;
  localparam logic [3:0] MOT_CCW          = 4'd5;
  localparam logic [3:0] MOT_STOP         = 4'd6;
  localparam logic [3:0] MOT_ROT_RIGHT    = 4'd7;
  localparam logic [3:0] MOT_ROT_LEFT     = 4'd8;

  // Result reasons
  localparam logic [1:0] RSN_COMMAND  = 2'd0;
  localparam logic [1:0] RSN_SAFETY   = 2'd1;
  localparam logic [1:0] RSN_ROT_RUN  = 2'd2;
  localparam logic [1:0] RSN_ROT_DONE = 2'd3;

  // Register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_HOLONOMIC = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_SPEED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_RATE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_TOL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_DIST = 3'd4;

  // Register reset values
  localparam logic        RST_HOLONOMIC = 1'b1;
  localparam logic [14:0] RST_FWD_SPEED = 15'd256;
  localparam logic [14:0] RST_TURN_RATE = 15'd128;
  localparam logic [14:0] RST_HEAD_TOL  = 15'd521;
  localparam logic [15:0] RST_SAFE_DIST = 16'd128;

  // A quarter turn in binary angle units
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         motion;
    logic signed [15:0] heading;
    logic [15:0]        wall_range;
  } item_t;

  typedef struct packed {
    logic signed [15:0] vel_forward;
    logic signed [15:0] vel_side;
    logic signed [15:0] vel_turn;
    logic [1:0]         emit_reason;
  } result_t;

  typedef struct packed {
    logic        holonomic_mode;
    logic [14:0] forward_speed;
    logic [14:0] turn_rate;
    logic [14:0] heading_tolerance;
    logic [15:0] safety_distance;
  } cfg_t;

  // Two's complement negation of a 15-bit magnitude into 16 bits
  function automatic logic signed [15:0] neg_mag(input logic [14:0] mag);
    logic [15:0] wide;
    wide = {1'b0, mag};
    return signed'(16'(-wide));
  endfunction

endpackage

/* rtl/mcs_core.sv */
// Decision logic and navigation state of the motion command sequencer.
// Depends on mcs_pkg; state moves only when the top level retires an item.
module mcs_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  mcs_pkg::item_t   item,
  input  mcs_pkg::cfg_t    cfg,
  output logic             produces,
  output mcs_pkg::result_t result
);
  import mcs_pkg::*;

  logic        rotating, rotating_next;
  logic [15:0] target_heading, target_heading_next;
  logic        rotate_clockwise, rotate_clockwise_next;
  logic [15:0] last_heading, last_heading_next;
  logic        heading_seen, heading_seen_next;
  logic [15:0] last_wall_range, last_wall_range_next;
  logic        distance_seen, distance_seen_next;

  logic [15:0] err;
  logic [16:0] err_mag;
  logic        rot_done;
  logic        too_close;
  logic signed [15:0] fwd_pos, turn_pos;

  always_comb begin
    // wrapped error; half a turn gives magnitude 32768, never inside tolerance
    err      = target_heading - 16'(item.heading);
    err_mag  = err[15] ? 17'(-{err[15], err}) : {1'b0, err};
    rot_done = err_mag < {2'b00, cfg.heading_tolerance};
    too_close = distance_seen && (last_wall_range != 16'd0) &&
                (last_wall_range < cfg.safety_distance);
    fwd_pos  = signed'({1'b0, cfg.forward_speed});
    turn_pos = signed'({1'b0, cfg.turn_rate});
  end

  always_comb begin
    rotating_next         = rotating;
    target_heading_next   = target_heading;
    rotate_clockwise_next = rotate_clockwise;
    last_heading_next     = last_heading;
    heading_seen_next     = heading_seen;
    last_wall_range_next  = last_wall_range;
    distance_seen_next    = distance_seen;
    produces              = 1'b0;
    result                = '0;

    case (item.cmd)
      CMD_HEADING: begin
        last_heading_next = 16'(item.heading);
        heading_seen_next = 1'b1;
        if (rotating) begin
          produces = 1'b1;
          if (rot_done) begin
            rotating_next      = 1'b0;
            result.emit_reason = RSN_ROT_DONE;
          end else begin
            result.vel_turn    = rotate_clockwise ? neg_mag(cfg.turn_rate) : turn_pos;
            result.emit_reason = RSN_ROT_RUN;
          end
        end
      end
      CMD_DIST: begin
        last_wall_range_next = item.wall_range;
        distance_seen_next   = 1'b1;
      end
      CMD_MOTION: begin
        if (!rotating) begin
          if (item.motion == MOT_ROT_RIGHT || item.motion == MOT_ROT_LEFT) begin
            // arm only once a heading is on record
            if (heading_seen) begin
              rotate_clockwise_next = (item.motion == MOT_ROT_RIGHT);
              target_heading_next   = (item.motion == MOT_ROT_RIGHT) ?
                                      last_heading - QUARTER_TURN :
                                      last_heading + QUARTER_TURN;
              rotating_next         = 1'b1;
            end
          end else begin
            produces           = 1'b1;
            result.emit_reason = RSN_COMMAND;
            case (item.motion)
              MOT_FWD: begin
                if (too_close) result.emit_reason = RSN_SAFETY;
                else           result.vel_forward = fwd_pos;
              end
              MOT_BACK:         result.vel_forward = neg_mag(cfg.forward_speed);
              MOT_STRAFE_LEFT: begin
                if (cfg.holonomic_mode) result.vel_side = fwd_pos;
              end
              MOT_STRAFE_RIGHT: begin
                if (cfg.holonomic_mode) result.vel_side = neg_mag(cfg.forward_speed);
              end
              MOT_CW:           result.vel_turn = neg_mag(cfg.turn_rate);
              MOT_CCW:          result.vel_turn = turn_pos;
              MOT_STOP:         result.vel_turn = '0;
              default:          result.vel_turn = '0;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rotating         <= 1'b0;
      target_heading   <= '0;
      rotate_clockwise <= 1'b0;
      last_heading     <= '0;
      heading_seen     <= 1'b0;
      last_wall_range  <= '0;
      distance_seen    <= 1'b0;
    end else if (fire) begin
      rotating         <= rotating_next;
      target_heading   <= target_heading_next;
      rotate_clockwise <= rotate_clockwise_next;
      last_heading     <= last_heading_next;
      heading_seen     <= heading_seen_next;
      last_wall_range  <= last_wall_range_next;
      distance_seen    <= distance_seen_next;
    end
  end

endmodule

/* rtl/motion_command_sequencer.sv */
// Channel  | Dir | Handshake            | Payload
// item     | in  | item_valid/stall     | mcs_pkg::item_t (cmd, motion, heading, distance)
// result   | out | result_valid/stall   | mcs_pkg::result_t (three velocities, reason)
// cfg      | in  | cfg_we               | cfg_index, cfg_data
//
// One item per cycle while results are not stalled: an item is held in the input register,
// is decided by mcs_core and lands in the result register, which offers the result.
// An item that yields no result retires even while the result register is stalled; the
// input register takes one more item behind a held result. Synchronous active-high
// reset clears state and loads register defaults.
// Top level; depends on mcs_pkg and mcs_core.
module motion_command_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  mcs_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output mcs_pkg::result_t                result,
  input  logic                            cfg_we,
  input  logic [mcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mcs_pkg::*;

  cfg_t    cfg;
  logic    in_valid;
  item_t   in_item;
  logic    produces;
  result_t decided;
  logic    advance;

  // retire the held item unless it has a result with nowhere to go
  assign advance    = in_valid && (!produces || !result_valid || !result_stall);
  assign item_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.holonomic_mode    <= RST_HOLONOMIC;
      cfg.forward_speed     <= RST_FWD_SPEED;
      cfg.turn_rate         <= RST_TURN_RATE;
      cfg.heading_tolerance <= RST_HEAD_TOL;
      cfg.safety_distance   <= RST_SAFE_DIST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOLONOMIC: cfg.holonomic_mode    <= cfg_data[0];
        REG_FWD_SPEED: cfg.forward_speed     <= cfg_data[14:0];
        REG_TURN_RATE: cfg.turn_rate         <= cfg_data[14:0];
        REG_HEAD_TOL:  cfg.heading_tolerance <= cfg_data[14:0];
        REG_SAFE_DIST: cfg.safety_distance   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!item_stall) begin
      in_valid <= item_valid;
    end
    if (item_valid && !item_stall) begin
      in_item <= item;
    end
  end

  mcs_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (advance),
    .item     (in_item),
    .cfg      (cfg),
    .produces (produces),
    .result   (decided)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && produces) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance && produces) begin
      result <= decided;
    end
  end

endmodule

/* test/motion_command_sequencer_test.sv */
// Self-checking testbench for motion_command_sequencer: directed and random items,
// register settings, random idling on both channels and a long result hold-off.
// Depends on mcs_pkg and the motion_command_sequencer RTL.
`timescale 1ns / 100ps

module motion_command_sequencer_test;
  import mcs_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic [3:0] MOT_UNKNOWN_LOW = MOT_ROT_LEFT + 4'd1;
  localparam logic [3:0] MOT_UNKNOWN_TOP = 4'd15;
  localparam int NUM_REGS = 5;
  localparam int SETTLE_CYCLES = 6;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS = 185;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int ITEM_W = $bits(item_t);
  localparam int CFG_W = $bits(cfg_t);

  // Mirrors the sequencer state and queues the velocity results it must emit
  class velocity_board;
    cfg_t cfg;
    bit rotating;
    logic [15:0] target_hd;
    bit rot_cw;
    logic [15:0] last_hd;
    bit hd_seen;
    logic [15:0] last_dist;
    bit dist_seen;
    result_t velocities_due[$];
    int errors;

    function new();
      cfg = '{RST_HOLONOMIC, RST_FWD_SPEED, RST_TURN_RATE, RST_HEAD_TOL, RST_SAFE_DIST};
      rotating = 0;
      target_hd = '0;
      rot_cw = 0;
      last_hd = '0;
      hd_seen = 0;
      last_dist = '0;
      dist_seen = 0;
      errors = 0;
    endfunction

    function logic signed [15:0] speed(input logic [14:0] mag, input bit negative);
      return negative ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
      case (idx)
        REG_HOLONOMIC: cfg.holonomic_mode = data[0];
        REG_FWD_SPEED: cfg.forward_speed = data[14:0];
        REG_TURN_RATE: cfg.turn_rate = data[14:0];
        REG_HEAD_TOL:  cfg.heading_tolerance = data[14:0];
        REG_SAFE_DIST: cfg.safety_distance = data;
        default: ;
      endcase
    endfunction

    function void note_item(input item_t it);
      logic [15:0] err;
      logic [16:0] mag;
      result_t r;
      r = '0;
      case (it.cmd)
        CMD_HEADING: begin
          last_hd = it.heading;
          hd_seen = 1;
          if (!rotating) return;
          err = target_hd - it.heading;
          mag = err[15] ? 17'h10000 - {1'b0, err} : {1'b0, err};
          if (mag < {2'b0, cfg.heading_tolerance}) begin
            rotating = 0;
            r.emit_reason = RSN_ROT_DONE;
          end else begin
            r.vel_turn = speed(cfg.turn_rate, rot_cw);
            r.emit_reason = RSN_ROT_RUN;
          end
          velocities_due.push_back(r);
        end
        CMD_DIST: begin
          last_dist = it.wall_range;
          dist_seen = 1;
        end
        CMD_MOTION: begin
          if (rotating) return;
          if (it.motion == MOT_ROT_RIGHT || it.motion == MOT_ROT_LEFT) begin
            if (!hd_seen) return;
            rot_cw = (it.motion == MOT_ROT_RIGHT);
            target_hd = rot_cw ? last_hd - QUARTER_TURN : last_hd + QUARTER_TURN;
            rotating = 1;
            return;
          end
          if (it.motion == MOT_FWD && dist_seen && last_dist != 0 &&
              last_dist < cfg.safety_distance) begin
            r.emit_reason = RSN_SAFETY;
          end else begin
            r.emit_reason = RSN_COMMAND;
            case (it.motion)
              MOT_FWD:  r.vel_forward = speed(cfg.forward_speed, 0);
              MOT_BACK: r.vel_forward = speed(cfg.forward_speed, 1);
              MOT_STRAFE_LEFT:  if (cfg.holonomic_mode) r.vel_side = speed(cfg.forward_speed, 0);
              MOT_STRAFE_RIGHT: if (cfg.holonomic_mode) r.vel_side = speed(cfg.forward_speed, 1);
              MOT_CW:  r.vel_turn = speed(cfg.turn_rate, 1);
              MOT_CCW: r.vel_turn = speed(cfg.turn_rate, 0);
              default: ;
            endcase
          end
          velocities_due.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void report(input string field, input logic [15:0] want, input logic [15:0] got);
      errors++;
      $display("%0t: %s expected %h got %h", $time, field, want, got);
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (velocities_due.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, got %h", $time, got);
        return;
      end
      want = velocities_due.pop_front();
      if (got.vel_forward !== want.vel_forward)
        report("vel_forward", want.vel_forward, got.vel_forward);
      if (got.vel_side !== want.vel_side) report("vel_side", want.vel_side, got.vel_side);
      if (got.vel_turn !== want.vel_turn) report("vel_turn", want.vel_turn, got.vel_turn);
      if (got.emit_reason !== want.emit_reason)
        report("emit_reason", 16'(want.emit_reason), 16'(got.emit_reason));
    endfunction

    function int due();
      return velocities_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  velocity_board sb = new();
  bit steady = 0;
  int hold_request = 0;
  int dead_cycles = 0;

  motion_command_sequencer uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we) begin
      dead_cycles <= 0;
    end else if (dead_cycles == WATCHDOG_LIMIT) begin
      $display("motion_command_sequencer: mismatch");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

  // Result side stalls: random bursts, plus one long hold-off on request
  initial begin : result_stalls
    int n;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
        result_stall <= 1'b0;
      end else if (!steady && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 11);
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  function automatic item_t mk(input logic [1:0] kind, input logic [3:0] mot,
                               input logic [15:0] hd, input logic [15:0] wall);
    item_t it;
    it.cmd = kind;
    it.motion = mot;
    it.heading = hd;
    it.wall_range = wall;
    return it;
  endfunction

  // Offer one item, hold it until taken, then maybe leave a gap
  task automatic send_item(input item_t it);
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
    if (!steady && $urandom_range(0, 7) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.due() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Write every register with junk in the unused high bits, then a stray index
  task automatic configure(input cfg_t c);
    logic [15:0] junk;
    junk = 16'($urandom);
    put_reg(REG_HOLONOMIC, {junk[15:1], c.holonomic_mode});
    put_reg(REG_FWD_SPEED, {junk[15], c.forward_speed});
    put_reg(REG_TURN_RATE, {junk[14], c.turn_rate});
    put_reg(REG_HEAD_TOL, {junk[13], c.heading_tolerance});
    put_reg(REG_SAFE_DIST, c.safety_distance);
    put_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)), 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic item_t random_item();
    item_t it;
    int sel;
    int off;
    int tol;
    it = item_t'(ITEM_W'({$urandom, $urandom}));
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      it.cmd = CMD_MOTION;
      if ($urandom_range(0, 3) == 0) it.motion = $urandom_range(0, 1) ? MOT_ROT_RIGHT : MOT_ROT_LEFT;
    end else if (sel < 80) begin
      it.cmd = CMD_HEADING;
      // aim at the rotation target, often right at the tolerance edge
      if (sb.rotating && $urandom_range(0, 2) != 0) begin
        tol = int'(sb.cfg.heading_tolerance);
        if ($urandom_range(0, 1))
          off = ($urandom_range(0, 1) ? 1 : -1) * (tol - int'($urandom_range(0, 1)));
        else
          off = int'($urandom_range(0, 4 * tol + 4)) - (2 * tol + 2);
        it.heading = sb.target_hd + 16'(off);
      end
    end else if (sel < 95) begin
      it.cmd = CMD_DIST;
      case ($urandom_range(0, 4))
        0: it.wall_range = '0;
        1: it.wall_range = sb.cfg.safety_distance + 16'($urandom_range(0, 2)) - 16'd1;
        2: it.wall_range = 16'($urandom_range(0, sb.cfg.safety_distance));
        default: ;
      endcase
    end else begin
      it.cmd = CMD_NONE;
    end
    return it;
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_item(random_item());
    drain();
  endtask

  initial begin : stimulus
    cfg_t c;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset settings
    send_item(mk(CMD_MOTION, MOT_ROT_RIGHT, '1, '1));   // no heading yet: drop
    for (int m = MOT_FWD; m <= MOT_STOP; m++) send_item(mk(CMD_MOTION, 4'(m), '0, '0));
    send_item(mk(CMD_MOTION, MOT_UNKNOWN_LOW, '0, '0));
    send_item(mk(CMD_MOTION, MOT_UNKNOWN_TOP, '1, '1));
    send_item(mk(CMD_NONE, '1, '1, '1));
    send_item(mk(CMD_HEADING, MOT_FWD, 16'h8000, '0));
    send_item(mk(CMD_MOTION, MOT_ROT_LEFT, '0, '0));
    send_item(mk(CMD_MOTION, MOT_FWD, '0, '0));          // dropped while rotating
    send_item(mk(CMD_HEADING, MOT_FWD, 16'h4000, '0));   // error of half a turn
    send_item(mk(CMD_HEADING, MOT_FWD, 16'hC000 - 16'(RST_HEAD_TOL), '0));
    send_item(mk(CMD_HEADING, MOT_FWD, 16'hC000 - 16'(RST_HEAD_TOL) + 16'd1, '0));
    send_item(mk(CMD_MOTION, MOT_ROT_RIGHT, '0, '0));
    send_item(mk(CMD_HEADING, MOT_FWD, 16'h0000, '0));
    send_item(mk(CMD_HEADING, MOT_FWD, 16'h8000, '0));
    send_item(mk(CMD_DIST, MOT_FWD, '0, 16'hFFFF));
    send_item(mk(CMD_MOTION, MOT_FWD, '0, '0));
    send_item(mk(CMD_DIST, MOT_FWD, '0, RST_SAFE_DIST - 16'd1));
    send_item(mk(CMD_MOTION, MOT_FWD, '0, '0));          // safety stop
    send_item(mk(CMD_DIST, MOT_FWD, '0, '0));
    send_item(mk(CMD_MOTION, MOT_FWD, '0, '0));
    drain();

    configure('{1'b0, 15'h7FFF, 15'h7FFF, 15'd16384, 16'hFFFF});
    run_random(PHASE_ITEMS);

    configure('{1'b1, 15'd0, 15'd0, 15'd0, 16'd0});
    run_random(PHASE_ITEMS);

    configure('{1'b1, 15'h7FFF, 15'd1, 15'h7FFF, 16'd1});
    run_random(PHASE_ITEMS);

    // Long result hold-off while items keep coming: fill up and stall the input
    c = cfg_t'(CFG_W'({$urandom, $urandom}));
    configure(c);
    hold_request = HOLD_OFF_CYCLES;
    run_random(PHASE_ITEMS);

    c = cfg_t'(CFG_W'({$urandom, $urandom}));
    configure(c);
    steady = 1;
    run_random(PHASE_ITEMS);

    if (sb.errors == 0 && sb.due() == 0) begin
      $display("motion_command_sequencer: match");
    end else begin
      $display("motion_command_sequencer: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/mcs_pkg.sv
rtl/mcs_core.sv
rtl/motion_command_sequencer.sv
test/motion_command_sequencer_test.sv
